// ----- src/color_gradient_evaluator_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the color gradient evaluator
// Shared property wrappers; clock is clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COLOR_GRADIENT_EVALUATOR_UNIT_DEFINES_SVH
`define COLOR_GRADIENT_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cge_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cge_pkg
// Shared widths, codes and the blend request type.
// ---------------------------------------------------------------------------
package cge_pkg;

  localparam int TIME_W       = 17;
  localparam int CH_W         = 8;
  localparam int NUM_CH       = 4;
  localparam int COLOR_W      = CH_W * NUM_CH;
  localparam int KEY_W        = TIME_W + COLOR_W;
  localparam int KEY_CNT_W    = 4;
  localparam int KEY_IDX_W    = 3;
  localparam int NUM_W        = TIME_W + CH_W;  // blend numerator width
  localparam int MAX_KEYS_DEF = 8;
  localparam int PADDR_W      = 3;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = '1;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // register indexes
  localparam logic REG_KEY_COUNT = 1'b0;

  typedef struct packed {
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    logic [TIME_W-1:0]  r;  // segment length
    logic [TIME_W-1:0]  d;  // offset into segment
  } blend_req_t;

endpackage

// ----- src/color_gradient_evaluator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_gradient_evaluator_unit
// Piecewise-linear RGBA gradient over a table of up to MAX_KEYS keys.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid / in_ready     | cmd, key index/time/color, sample_pos
//  out     | out_valid / out_ready   | out_red/green/blue/alpha
//  config  | psel/penable/pwrite     | key_count at address 0
//
//  Load request: written straight into the key table.
//  Evaluate: an empty table goes straight to the output; else up to n+1 key
//  reads (key 0, key n-1, then keys 1 upward); a blend adds 4 numerator
//  steps and 8 steps of the shared divider.
//  One request in flight; a finished color waits in the output register
//  while the next request is taken. Reset clears control and key_count only.
// ---------------------------------------------------------------------------
`include "color_gradient_evaluator_unit_defines.svh"

module color_gradient_evaluator_unit #(
  parameter int MAX_KEYS = cge_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [cge_pkg::KEY_IDX_W-1:0]      in_key_index,
  input  logic [cge_pkg::TIME_W-1:0]         in_key_time,
  input  logic [cge_pkg::CH_W-1:0]           in_key_red,
  input  logic [cge_pkg::CH_W-1:0]           in_key_green,
  input  logic [cge_pkg::CH_W-1:0]           in_key_blue,
  input  logic [cge_pkg::CH_W-1:0]           in_key_alpha,
  input  logic [cge_pkg::TIME_W-1:0]         in_sample_pos,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cge_pkg::CH_W-1:0]           out_red,
  output logic [cge_pkg::CH_W-1:0]           out_green,
  output logic [cge_pkg::CH_W-1:0]           out_blue,
  output logic [cge_pkg::CH_W-1:0]           out_alpha,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cge_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // table address width and clamped-count width
  localparam int AW  = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int NCW = ($clog2(MAX_KEYS + 1) > cge_pkg::KEY_CNT_W) ?
                       $clog2(MAX_KEYS + 1) : cge_pkg::KEY_CNT_W;
  localparam int TW  = cge_pkg::TIME_W;
  localparam int CLW = cge_pkg::COLOR_W;

  // one-hot sequencer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,  // read data holds key 0
    S_LAST  = 6'b000100,  // read data holds key n-1
    S_SCAN  = 6'b001000,  // read data holds key idx_r
    S_DIV   = 6'b010000,  // waiting on the blend unit
    S_OUT   = 6'b100000   // result ready for the output register
  } state_t;

  state_t                  state_r, state_nxt;
  logic [cge_pkg::KEY_CNT_W-1:0] key_count_r;
  logic [NCW-1:0]          n_r, n_nxt;
  logic [TW-1:0]           t_r;
  logic [AW-1:0]           idx_r;
  logic [AW-1:0]           last_addr;
  logic [TW-1:0]           prev_time_r;
  logic [CLW-1:0]          prev_color_r;
  logic [CLW-1:0]          last_color_r;
  logic [CLW-1:0]          res_r;
  logic                    out_valid_r;
  logic [CLW-1:0]          out_color_r;

  // key RAM
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [cge_pkg::KEY_W-1:0] mem_wdata, mem_rdata_r;
  logic [TW-1:0]             rd_time;
  logic [CLW-1:0]            rd_color;

  // blend unit
  logic                  blend_start, blend_done;
  cge_pkg::blend_req_t   blend_req;
  logic [CLW-1:0]        blend_color;

  logic in_acc, is_eval, out_free, seg_hit, cfg_wr, empty_eval;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_eval   = (in_cmd == cge_pkg::CMD_EVAL);
  assign out_free  = !out_valid_r || out_ready;
  assign rd_time   = mem_rdata_r[cge_pkg::KEY_W-1:CLW];
  assign rd_color  = mem_rdata_r[CLW-1:0];
  assign last_addr = AW'(n_r - NCW'(1));
  // t inside [t1, t2]; t1 is the previous key
  assign seg_hit   = (t_r >= prev_time_r) && (t_r <= rd_time);

  // a count above the table size is used as the table size
  assign n_nxt = (NCW'(key_count_r) > NCW'(MAX_KEYS)) ? NCW'(MAX_KEYS)
                                                      : NCW'(key_count_r);
  assign empty_eval = in_acc && is_eval && (n_nxt == '0);

  // ---- config port: single register, zero-wait ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cge_pkg::REG_KEY_COUNT) ?
                  32'(key_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_wr && (paddr[2] == cge_pkg::REG_KEY_COUNT)) begin
      key_count_r <= pwdata[cge_pkg::KEY_CNT_W-1:0];
    end
  end

  // ---- key table write: loads go straight in; out-of-range slots dropped ----
  assign mem_we    = in_acc && !is_eval && (32'(in_key_index) < MAX_KEYS);
  assign mem_waddr = AW'(in_key_index);
  assign mem_wdata = {in_key_time, in_key_alpha, in_key_blue, in_key_green, in_key_red};

  // ---- sequencer ----
  always_comb begin
    state_nxt   = state_r;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    blend_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_eval) begin
          if (n_nxt == '0) begin
            state_nxt = S_OUT;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (t_r <= rd_time) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = last_addr;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // going on to the scan implies at least two keys
        if (t_r >= rd_time) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (seg_hit) begin
          if (rd_time == prev_time_r) begin
            state_nxt = S_OUT;
          end else begin
            blend_start = 1'b1;
            state_nxt   = S_DIV;
          end
        end else if (idx_r == last_addr) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
        end
      end
      S_DIV: begin
        if (blend_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- sequencer datapath ----
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          t_r   <= in_sample_pos;
          n_r   <= n_nxt;
          idx_r <= AW'(1);
          res_r <= cge_pkg::COLOR_WHITE;
        end
      end
      S_FIRST: begin
        prev_time_r  <= rd_time;
        prev_color_r <= rd_color;
        res_r        <= rd_color;
      end
      S_LAST: begin
        last_color_r <= rd_color;
        res_r        <= rd_color;
      end
      S_SCAN: begin
        if (seg_hit) begin
          res_r <= prev_color_r;  // zero-length segment keeps the earlier key
        end else begin
          prev_time_r  <= rd_time;
          prev_color_r <= rd_color;
          idx_r        <= idx_r + AW'(1);
          res_r        <= last_color_r;  // no segment matched
        end
      end
      S_DIV: begin
        if (blend_done) res_r <= blend_color;
      end
      default: ;
    endcase
  end

  assign blend_req.c1 = prev_color_r;
  assign blend_req.c2 = rd_color;
  assign blend_req.r  = rd_time - prev_time_r;
  assign blend_req.d  = t_r - prev_time_r;

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_color_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r[7:0];
  assign out_green = out_color_r[15:8];
  assign out_blue  = out_color_r[23:16];
  assign out_alpha = out_color_r[31:24];

  // ---- submodules ----
  cge_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata_r)
  );

  cge_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (blend_start),
    .req    (blend_req),
    .done_r (blend_done),
    .color  (blend_color)
  );

  // ---- assertions ----
  `CGE_ASSERT_NOW(a_blend_two_keys, state_r == S_DIV, n_r >= NCW'(2), "blend on short table")
  `CGE_ASSERT_NOW(a_done_in_wait, blend_done, state_r == S_DIV, "blend done outside wait")
  `CGE_ASSERT_NEXT(a_empty_to_out, empty_eval, state_r == S_OUT, "empty table not sent out")

endmodule

// ----- src/cge_key_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cge_key_mem
// Key table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cge_key_mem #(
  parameter int DEPTH = cge_pkg::MAX_KEYS_DEF,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cge_pkg::KEY_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cge_pkg::KEY_W-1:0] rdata_r
);

  logic [cge_pkg::KEY_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- src/cge_blend.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cge_blend
// Per-channel blend: one channel numerator per cycle, then a shared
// 8-step restoring division run on all four channels side by side.
// ---------------------------------------------------------------------------
module cge_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  cge_pkg::blend_req_t         req,
  output logic                        done_r,
  output logic [cge_pkg::COLOR_W-1:0] color
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_DIV  = 3'b100
  } bstate_t;

  localparam int CW = cge_pkg::CH_W;
  localparam int TW = cge_pkg::TIME_W;

  bstate_t             state_r, state_nxt;
  cge_pkg::blend_req_t req_r;
  logic [2:0]          cnt_r;
  logic [1:0]          ch;
  logic [CW-1:0]       lo_r  [cge_pkg::NUM_CH];
  logic [TW-1:0]       rem_r [cge_pkg::NUM_CH];
  logic [CW-1:0]       q_r   [cge_pkg::NUM_CH];
  logic [CW-1:0]       a_ch, b_ch;
  logic [cge_pkg::NUM_W-1:0] num;

  assign ch   = cnt_r[1:0];
  assign a_ch = req_r.c1[CW*ch +: CW];
  assign b_ch = req_r.c2[CW*ch +: CW];
  // a*(r-d) + b*d + r/2, below 256*r
  assign num  = cge_pkg::NUM_W'(a_ch) * cge_pkg::NUM_W'(req_r.r - req_r.d)
              + cge_pkg::NUM_W'(b_ch) * cge_pkg::NUM_W'(req_r.d)
              + cge_pkg::NUM_W'(req_r.r >> 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (start) state_nxt = B_MUL;
      B_MUL:   if (cnt_r == 3'd3) state_nxt = B_DIV;
      B_DIV:   if (cnt_r == 3'd0) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == B_DIV) && (cnt_r == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    logic [TW:0] trial;
    logic        ge;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          req_r <= req;
          cnt_r <= 3'd0;
        end
      end
      B_MUL: begin
        rem_r[ch] <= num[cge_pkg::NUM_W-1:CW];
        lo_r[ch]  <= num[CW-1:0];
        cnt_r     <= (cnt_r == 3'd3) ? 3'd7 : cnt_r + 3'd1;
      end
      B_DIV: begin
        for (int c = 0; c < cge_pkg::NUM_CH; c++) begin
          trial    = {rem_r[c], lo_r[c][cnt_r]};
          ge       = trial >= {1'b0, req_r.r};
          rem_r[c] <= ge ? TW'(trial - {1'b0, req_r.r}) : trial[TW-1:0];
          q_r[c]   <= {q_r[c][CW-2:0], ge};
        end
        cnt_r <= cnt_r - 3'd1;
      end
      default: ;
    endcase
  end

  assign color = {q_r[3], q_r[2], q_r[1], q_r[0]};

endmodule

// ----- test/color_gradient_evaluator_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_gradient_evaluator_unit_tb
// Self-checking bench for the piecewise-linear RGBA gradient unit. A short
// scripted sequence covers the empty table, table edges, blends, clamped and
// unsorted key counts; then randomized phases load mostly sorted key tables
// with random colors and sample them, each color checked against an
// in-bench gradient predictor.
// ---------------------------------------------------------------------------
module color_gradient_evaluator_unit_tb;

  localparam int TIME_W    = cge_pkg::TIME_W;
  localparam int CH_W      = cge_pkg::CH_W;
  localparam int KEY_IDX_W = cge_pkg::KEY_IDX_W;
  localparam int KEY_CNT_W = cge_pkg::KEY_CNT_W;
  localparam int PADDR_W   = cge_pkg::PADDR_W;

  localparam int NKEYS          = cge_pkg::MAX_KEYS_DEF;
  localparam int SETTLE_CYCLES  = 40;       // more than the slowest evaluation takes
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_REQUESTS = 65;
  localparam logic [TIME_W-1:0] T_ONE = 17'd65536;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  // red in the low byte, as the key table packs it
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic                 cmd;
    logic [KEY_IDX_W-1:0] slot;
    logic [TIME_W-1:0]    key_t;
    rgba_t                color;
    logic [TIME_W-1:0]    pos;
  } request_t;

  typedef enum logic [1:0] {STEP_SET_COUNT, STEP_REQUEST} step_kind_t;

  // one row of the scripted sequence; typed rows carry their own answer
  typedef struct packed {
    step_kind_t           kind;
    logic [KEY_CNT_W-1:0] count;
    request_t             req;
    logic                 typed;
    rgba_t                typed_color;
  } script_row_t;

  // -------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // -------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_cmd        = cge_pkg::CMD_LOAD;
  logic [KEY_IDX_W-1:0] in_key_index  = '0;
  logic [TIME_W-1:0]    in_key_time   = '0;
  logic [CH_W-1:0]      in_key_red    = '0;
  logic [CH_W-1:0]      in_key_green  = '0;
  logic [CH_W-1:0]      in_key_blue   = '0;
  logic [CH_W-1:0]      in_key_alpha  = '0;
  logic [TIME_W-1:0]    in_sample_pos = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [CH_W-1:0]      out_alpha;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  color_gradient_evaluator_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_key_index  (in_key_index),
    .in_key_time   (in_key_time),
    .in_key_red    (in_key_red),
    .in_key_green  (in_key_green),
    .in_key_blue   (in_key_blue),
    .in_key_alpha  (in_key_alpha),
    .in_sample_pos (in_sample_pos),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor state: shadow key table and key_count
  // -------------------------------------------------------------------------
  logic [TIME_W-1:0]    key_time_tab [NKEYS];
  rgba_t                key_rgba_tab [NKEYS];
  logic [KEY_CNT_W-1:0] key_count_sh = '0;

  rgba_t       expected_colors [$];
  script_row_t script_q [$];

  int  err_count    = 0;
  int  load_count   = 0;
  int  eval_count   = 0;
  int  color_count  = 0;
  int  count_writes = 0;
  int  out_stall    = 0;
  bit  quiet        = 1'b0;   // no gaps and no stalls on either side

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // one channel: round-half-up linear mix over a segment of length r
  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b,
                                                  input int unsigned r,
                                                  input int unsigned d);
    int unsigned acc;
    acc = a * (r - d) + b * d + r / 2;
    return CH_W'(acc / r);
  endfunction

  function automatic rgba_t gradient_at(input logic [TIME_W-1:0] t);
    int    n;
    int    i;
    rgba_t c1;
    rgba_t c2;
    rgba_t res;
    int unsigned r;
    int unsigned d;
    // counts beyond the table size clamp to the table size
    n = (key_count_sh > NKEYS) ? NKEYS : int'(key_count_sh);
    if (n == 0) return rgba_t'(cge_pkg::COLOR_WHITE);
    if (t <= key_time_tab[0]) return key_rgba_tab[0];
    if (t >= key_time_tab[n-1]) return key_rgba_tab[n-1];
    // first segment that holds t wins, even on an unsorted table
    for (i = 0; i + 1 < n; i++) begin
      if (t >= key_time_tab[i] && t <= key_time_tab[i+1]) begin
        if (key_time_tab[i] == key_time_tab[i+1]) return key_rgba_tab[i];
        c1 = key_rgba_tab[i];
        c2 = key_rgba_tab[i+1];
        r  = key_time_tab[i+1] - key_time_tab[i];
        d  = t - key_time_tab[i];
        res.red   = mix_channel(c1.red,   c2.red,   r, d);
        res.green = mix_channel(c1.green, c2.green, r, d);
        res.blue  = mix_channel(c1.blue,  c2.blue,  r, d);
        res.alpha = mix_channel(c1.alpha, c2.alpha, r, d);
        return res;
      end
    end
    return key_rgba_tab[n-1];
  endfunction

  function automatic rgba_t mk_rgba(input int r, input int g, input int b, input int a);
    rgba_t c;
    c.red   = CH_W'(r);
    c.green = CH_W'(g);
    c.blue  = CH_W'(b);
    c.alpha = CH_W'(a);
    return c;
  endfunction

  function automatic rgba_t random_rgba();
    return rgba_t'($urandom);
  endfunction

  function automatic request_t load_req(input int slot, input logic [TIME_W-1:0] t,
                                        input rgba_t c);
    request_t rq;
    rq       = '0;
    rq.cmd   = cge_pkg::CMD_LOAD;
    rq.slot  = KEY_IDX_W'(slot);
    rq.key_t = t;
    rq.color = c;
    rq.pos   = TIME_W'($urandom);   // don't-care on a load, keep it moving
    return rq;
  endfunction

  function automatic request_t eval_req(input logic [TIME_W-1:0] pos);
    request_t rq;
    rq       = '0;
    rq.cmd   = cge_pkg::CMD_EVAL;
    rq.slot  = KEY_IDX_W'($urandom);
    rq.key_t = TIME_W'($urandom);
    rq.color = random_rgba();
    rq.pos   = pos;
    return rq;
  endfunction

  // -------------------------------------------------------------------------
  // Script helpers
  // -------------------------------------------------------------------------
  function automatic void add_count(input int n);
    script_row_t row;
    row       = '0;
    row.kind  = STEP_SET_COUNT;
    row.count = KEY_CNT_W'(n);
    script_q.insert(script_q.size(), row);
  endfunction

  function automatic void add_req(input request_t rq, input bit typed, input rgba_t want);
    script_row_t row;
    row             = '0;
    row.kind        = STEP_REQUEST;
    row.req         = rq;
    row.typed       = typed;
    row.typed_color = want;
    script_q.insert(script_q.size(), row);
  endfunction

  // -------------------------------------------------------------------------
  // Request driver: payload changes at negedge, acceptance seen at posedge.
  // The predictor runs on the accepting edge so loads and evaluations stay in
  // request order.
  // -------------------------------------------------------------------------
  task automatic issue_request(input request_t rq, input bit typed, input rgba_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= rq.cmd;
    in_key_index  <= rq.slot;
    in_key_time   <= rq.key_t;
    in_key_red    <= rq.color.red;
    in_key_green  <= rq.color.green;
    in_key_blue   <= rq.color.blue;
    in_key_alpha  <= rq.color.alpha;
    in_sample_pos <= rq.pos;
    do @(posedge clk); while (!in_ready);
    if (rq.cmd == cge_pkg::CMD_LOAD) begin
      key_time_tab[rq.slot] = rq.key_t;
      key_rgba_tab[rq.slot] = rq.color;
      load_count++;
    end else begin
      expected_colors.insert(expected_colors.size(),
                             typed ? want : gradient_at(rq.pos));
      eval_count++;
    end
  endtask

  // Block goes idle: all colors back, then room for a trailing load or scan.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access; lands on the edge with pready high
  task automatic write_key_count(input int n);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cge_pkg::REG_KEY_COUNT, 2'b00};
    pwdata  <= 32'(n);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_count_sh = KEY_CNT_W'(n);
    count_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly ascending key times with random colors; now and then two keys
  // share a time, and the ends sometimes sit exactly on 0.0 and 1.0.
  task automatic load_sorted_table();
    int s;
    int t;
    t = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4096);
    for (s = 0; s < NKEYS; s++) begin
      if (s > 0 && $urandom_range(0, 9) != 0) t = t + $urandom_range(1, 12000);
      if (t > 65536 || (s == NKEYS - 1 && $urandom_range(0, 2) == 0)) t = 65536;
      issue_request(load_req(s, TIME_W'(t), random_rgba()), 1'b0, '0);
    end
  endtask

  function automatic logic [TIME_W-1:0] random_pos();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return TIME_W'($urandom_range(0, 65536));
    if (pick < 15) return key_time_tab[$urandom_range(0, NKEYS - 1)] +
                          TIME_W'($urandom_range(0, 1));
    if (pick < 17) return TIME_W'($urandom);
    if (pick == 17) return '0;
    if (pick == 18) return T_ONE;
    return T_MAX;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: a random stall after each color, compare on accept
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : color_check
    rgba_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("color with no evaluate pending",
                        {out_alpha, out_blue, out_green, out_red}, 0);
      end else begin
        want = expected_colors.pop_front();
        color_count++;
        if (out_red !== want.red)     report_mismatch("out_red",   out_red,   want.red);
        if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
        if (out_blue !== want.blue)   report_mismatch("out_blue",  out_blue,  want.blue);
        if (out_alpha !== want.alpha) report_mismatch("out_alpha", out_alpha, want.alpha);
      end
      out_stall = quiet ? 0 : $urandom_range(0, 4);
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    int          p;
    int          k;
    int          count;
    script_row_t row;
    request_t    rq;
    rgba_t       c0;
    rgba_t       c5;
    rgba_t       c7;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    c0 = mk_rgba(0, 255, 0, 255);
    c5 = mk_rgba(128, 64, 32, 16);
    c7 = mk_rgba(200, 100, 50, 25);

    // empty table after reset: opaque white regardless of t
    add_req(eval_req('0),    1'b1, rgba_t'(cge_pkg::COLOR_WHITE));
    add_req(eval_req(T_ONE), 1'b1, rgba_t'(cge_pkg::COLOR_WHITE));
    add_req(eval_req(T_MAX), 1'b1, rgba_t'(cge_pkg::COLOR_WHITE));
    // fill every slot: slots 1 and 2 share a time, slot 6 sits above 1.0,
    // slot 7 breaks the ordering
    add_req(load_req(0, '0,       c0), 1'b0, '0);
    add_req(load_req(1, 17'd16384, mk_rgba(255, 0, 255, 0)), 1'b0, '0);
    add_req(load_req(2, 17'd16384, mk_rgba(10, 20, 30, 40)), 1'b0, '0);
    add_req(load_req(3, 17'd32768, mk_rgba(255, 255, 255, 255)), 1'b0, '0);
    add_req(load_req(4, 17'd49152, mk_rgba(0, 0, 0, 0)), 1'b0, '0);
    add_req(load_req(5, T_ONE,     c5), 1'b0, '0);
    add_req(load_req(6, T_MAX,     mk_rgba(1, 2, 3, 4)), 1'b0, '0);
    add_req(load_req(7, 17'd100,   c7), 1'b0, '0);
    // single key: every t gives that key
    add_count(1);
    add_req(eval_req(T_ONE), 1'b1, c0);
    // sorted six-key table: both edges, mid-blend, shared-time boundary
    add_count(6);
    add_req(eval_req('0),       1'b1, c0);
    add_req(eval_req(T_ONE),    1'b1, c5);
    add_req(eval_req(17'd8192),  1'b0, '0);
    add_req(eval_req(17'd16384), 1'b0, '0);
    add_req(eval_req(17'd40000), 1'b0, '0);
    add_req(eval_req(17'd65535), 1'b0, '0);
    // count past the table size clamps to 8; last key is slot 7 at t=100
    add_count(15);
    add_req(eval_req(T_MAX),  1'b1, c7);
    add_req(eval_req(17'd50), 1'b0, '0);
    // seven keys: last key above 1.0, scan walks into the top segment
    add_count(7);
    add_req(eval_req(17'd70000),  1'b0, '0);
    add_req(eval_req(T_MAX - 1'b1), 1'b0, '0);

    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.kind == STEP_SET_COUNT) begin
        settle_block();
        write_key_count(row.count);
      end else begin
        issue_request(row.req, row.typed, row.typed_color);
      end
    end

    // Randomized phases: each picks a key_count (extremes first), mostly
    // reloads a well-formed table, then mixes evaluations with stray loads.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       count = NKEYS;
        1:       count = 2;
        2:       count = 0;
        3:       count = 15;
        4:       count = 1;
        5:       count = 9;
        default: count = $urandom_range(0, 15);
      endcase
      quiet = (p % 4 == 1);
      settle_block();
      write_key_count(count);
      if ($urandom_range(0, 3) != 0) load_sorted_table();
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          // stray load: sometimes in order, sometimes anywhere in 17 bits
          rq = load_req($urandom_range(0, NKEYS - 1),
                        ($urandom_range(0, 1) == 0) ? TIME_W'($urandom_range(0, 65536))
                                                     : TIME_W'($urandom),
                        random_rgba());
        end else begin
          rq = eval_req(random_pos());
        end
        issue_request(rq, 1'b0, '0);
      end
    end

    quiet = 1'b0;
    settle_block();
    if (expected_colors.size() != 0)
      report_mismatch("colors never returned", 0, expected_colors.size());

    $display("Covered %0d requests: %0d key loads, %0d evaluations, %0d key_count writes.",
             load_count + eval_count, load_count, eval_count, count_writes);
    $display("Compared %0d colors channel by channel, %0d mismatches.",
             color_count, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("Timeout: block stopped making progress.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/cge_pkg.sv
src/cge_key_mem.sv
src/cge_blend.sv
src/color_gradient_evaluator_unit.sv
test/color_gradient_evaluator_unit_tb.sv
